### rtl/sorted_list_engine_assert.svh
`ifndef SORTED_LIST_ENGINE_ASSERT_SVH
`define SORTED_LIST_ENGINE_ASSERT_SVH

// same-cycle implication, held off during reset
`define SLE_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sorted list engine check failed");

// next-cycle implication, held off during reset
`define SLE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sorted list engine check failed");

`endif

### rtl/sle_pkg.sv
`default_nettype none

package sle_pkg;

    localparam int VALUE_W = 32;
    localparam int OP_W    = 3;
    localparam int POS_W   = 4;
    localparam int CNT_W   = 5;
    localparam int IN_W    = 40;
    localparam int OUT_W   = 16;

    typedef logic signed [VALUE_W-1:0] value_t;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT     = 3'd0,
        OP_PUSH_FRONT = 3'd1,
        OP_PUSH_BACK  = 3'd2,
        OP_POP_FRONT  = 3'd3,
        OP_POP_BACK   = 3'd4,
        OP_FIND       = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_FULL      = 2'd1,
        STATUS_EMPTY     = 2'd2,
        STATUS_NOT_FOUND = 2'd3
    } status_t;

    typedef struct packed {
        logic load;
        logic shift_up;
        logic shift_down;
    } cell_ctl_t;

endpackage

`default_nettype wire

### rtl/sle_cell.sv
`default_nettype none

module sle_cell
    import sle_pkg::*;
(
    input  wire             clk,
    input  wire             cmp_en,
    input  wire value_t     cmp_value,
    input  wire value_t     load_value,
    input  wire value_t     left_entry,
    input  wire value_t     right_entry,
    input  wire cell_ctl_t  ctl,
    output value_t          entry,
    output logic            gt,
    output logic            eq
);

    value_t entry_reg;
    logic   gt_reg;
    logic   eq_reg;

    always_ff @(posedge clk)
    begin
        if (cmp_en)
        begin
            gt_reg <= entry_reg > cmp_value;
            eq_reg <= entry_reg == cmp_value;
        end
        priority if (ctl.load)
        begin
            entry_reg <= load_value;
        end
        else if (ctl.shift_up)
        begin
            entry_reg <= left_entry;
        end
        else if (ctl.shift_down)
        begin
            entry_reg <= right_entry;
        end
    end

    assign entry = entry_reg;
    assign gt    = gt_reg;
    assign eq    = eq_reg;

endmodule

`default_nettype wire

### rtl/sle_locate.sv
`default_nettype none

module sle_locate
    import sle_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int IW    = 4
)
(
    input  wire  [DEPTH-1:0] hit,
    output logic [DEPTH-1:0] at_or_after,
    output logic [DEPTH-1:0] first,
    output logic [IW-1:0]    first_idx,
    output logic             any_hit
);

    localparam int LV = $clog2(DEPTH);

    logic [DEPTH-1:0] pre [LV+1];

    assign pre[0] = hit;

    // log-depth prefix or along the chain
    for (genvar l = 0; l < LV; l++)
    begin : g_prefix
        assign pre[l+1] = pre[l] | (pre[l] << (2 ** l));
    end

    assign at_or_after = pre[LV];
    assign first       = hit & ~(pre[LV] << 1);
    assign any_hit     = pre[LV][DEPTH-1];

    always_comb
    begin
        first_idx = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (first[i])
            begin
                first_idx = first_idx | IW'(i);
            end
        end
    end

endmodule

`default_nettype wire

### rtl/sorted_list_engine.sv
// channel | dir | tdata fields (low bit first)                  | tuser
// s_      | in  | operation[2:0], value[34:3], zero pad [39:35]   | none
// m_      | out | status[1:0], position[5:2], entry_count[10:6]  | none
// each word passes through ST_IDLE and ST_EXEC: the accept edge latches the
// word and every cell registers its compare flags, then ST_EXEC shifts the
// cell chain and loads the result register; a stalled result holds the
// chain in ST_EXEC. reset clears the count and the handshake state only, the
// cell contents need no clearing.
`default_nettype none

module sorted_list_engine
    import sle_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  wire              clk,
    input  wire              rst_n,
    input  wire              s_tvalid,
    output logic             s_tready,
    input  wire  [IN_W-1:0]  s_tdata,   // operation, value
    output logic             m_tvalid,
    input  wire              m_tready,
    output logic [OUT_W-1:0] m_tdata    // status, position, entry_count
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    state_t            state_reg;
    op_t               op_reg;
    value_t            value_reg;
    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     count_next;
    logic              m_tvalid_reg;
    status_t           status_reg;
    status_t           status_next;
    logic [POS_W-1:0]  position_reg;
    logic [POS_W-1:0]  position_next;
    logic [CNT_W-1:0]  entry_count_reg;

    value_t            entry_w [DEPTH];
    logic [DEPTH-1:0]  gt_w;
    logic [DEPTH-1:0]  eq_w;
    logic [DEPTH-1:0]  hit;
    logic [DEPTH-1:0]  at_or_after;
    logic [DEPTH-1:0]  first;
    logic [IW-1:0]     first_idx;
    logic              any_hit;
    cell_ctl_t         ctl [DEPTH];

    logic              accept;
    logic              exec_fire;
    logic              is_full;
    logic              is_empty;
    logic              apply_ins;
    logic              apply_popf;
    logic [IW+POS_W-1:0] idx_ext;
    logic [CW+CNT_W-1:0] cnt_ext;

    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign exec_fire = (state_reg == ST_EXEC) && (!m_tvalid_reg || m_tready);
    assign is_full   = (count_reg == CW'(DEPTH));
    assign is_empty  = (count_reg == '0);

    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            unique case (op_reg)
                OP_INSERT:     hit[i] = (gt_w[i] && (CW'(i) < count_reg))
                                        || (CW'(i) == count_reg);
                OP_PUSH_FRONT: hit[i] = (i == 0);
                OP_PUSH_BACK:  hit[i] = (CW'(i) == count_reg);
                OP_FIND:       hit[i] = eq_w[i] && (CW'(i) < count_reg);
                default:       hit[i] = 1'b0;
            endcase
        end
    end

    sle_locate #(
        .DEPTH (DEPTH),
        .IW    (IW)
    ) u_locate (
        .hit         (hit),
        .at_or_after (at_or_after),
        .first       (first),
        .first_idx   (first_idx),
        .any_hit     (any_hit)
    );

    assign apply_ins  = exec_fire && !is_full
                        && (op_reg == OP_INSERT || op_reg == OP_PUSH_FRONT
                            || op_reg == OP_PUSH_BACK);
    assign apply_popf = exec_fire && !is_empty && (op_reg == OP_POP_FRONT);

    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            ctl[i].load       = apply_ins && first[i];
            ctl[i].shift_up   = apply_ins && at_or_after[i] && !first[i];
            ctl[i].shift_down = apply_popf;
        end
    end

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        value_t left_w;
        value_t right_w;

        if (i == 0)
        begin : g_head
            assign left_w = value_reg;
        end
        else
        begin : g_body
            assign left_w = entry_w[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_tail
            assign right_w = entry_w[i];
        end
        else
        begin : g_inner
            assign right_w = entry_w[i+1];
        end

        sle_cell u_cell (
            .clk         (clk),
            .cmp_en      (accept),
            .cmp_value   (value_t'(s_tdata[OP_W +: VALUE_W])),
            .load_value  (value_reg),
            .left_entry  (left_w),
            .right_entry (right_w),
            .ctl         (ctl[i]),
            .entry       (entry_w[i]),
            .gt          (gt_w[i]),
            .eq          (eq_w[i])
        );
    end

    assign idx_ext = (IW+POS_W)'(first_idx);

    always_comb
    begin
        status_next   = STATUS_OK;
        position_next = '0;
        count_next    = count_reg;
        unique case (op_reg)
            OP_INSERT, OP_PUSH_FRONT, OP_PUSH_BACK:
            begin
                if (is_full)
                begin
                    status_next = STATUS_FULL;
                end
                else
                begin
                    position_next = idx_ext[POS_W-1:0];
                    count_next    = count_reg + CW'(1);
                end
            end
            OP_POP_FRONT, OP_POP_BACK:
            begin
                if (is_empty)
                begin
                    status_next = STATUS_EMPTY;
                end
                else
                begin
                    count_next = count_reg - CW'(1);
                end
            end
            OP_FIND:
            begin
                if (any_hit)
                begin
                    position_next = idx_ext[POS_W-1:0];
                end
                else
                begin
                    status_next = STATUS_NOT_FOUND;
                end
            end
            default:
            begin
                status_next = STATUS_OK;
            end
        endcase
    end

    assign cnt_ext = (CW+CNT_W)'(count_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (m_tvalid_reg && m_tready && !exec_fire)
            begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        op_reg    <= op_t'(s_tdata[OP_W-1:0]);
                        value_reg <= value_t'(s_tdata[OP_W +: VALUE_W]);
                        state_reg <= ST_EXEC;
                    end
                end
                ST_EXEC:
                begin
                    if (exec_fire)
                    begin
                        count_reg       <= count_next;
                        status_reg      <= status_next;
                        position_reg    <= position_next;
                        entry_count_reg <= cnt_ext[CNT_W-1:0];
                        m_tvalid_reg    <= 1'b1;
                        state_reg       <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(OUT_W-2-POS_W-CNT_W){1'b0}}, entry_count_reg, position_reg,
                       status_reg};

endmodule

`default_nettype wire

### rtl/sle_checker.sv
`default_nettype none

`include "sorted_list_engine_assert.svh"

module sle_checker
    import sle_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input wire             clk,
    input wire             rst_n,
    input wire             s_tvalid,
    input wire             s_tready,
    input wire [IN_W-1:0]  s_tdata,
    input wire             m_tvalid,
    input wire             m_tready,
    input wire [OUT_W-1:0] m_tdata
);

    logic [1:0]       st;
    logic [POS_W-1:0] pos;
    logic [CNT_W-1:0] cnt;
    logic             small_list;

    assign st         = m_tdata[1:0];
    assign pos        = m_tdata[5:2];
    assign cnt        = m_tdata[10:6];
    assign small_list = (DEPTH < 32);

    // stalled result word holds
    `SLE_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // one word in execution at a time
    `SLE_ASSERT_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready)

    // failures report position zero
    `SLE_ASSERT_NOW(a_fail_pos_zero, m_tvalid && st != STATUS_OK, pos == '0)

    // full only at capacity, and never above it
    `SLE_ASSERT_NOW(a_full_count, m_tvalid && st == STATUS_FULL && small_list,
        cnt == CNT_W'(DEPTH))
    `SLE_ASSERT_NOW(a_count_bound, m_tvalid && small_list, cnt <= CNT_W'(DEPTH))

endmodule

bind sorted_list_engine sle_checker #(.DEPTH(DEPTH)) u_checker (.*);

`default_nettype wire

### tb/list_result_checker.sv
`default_nettype none

module list_result_checker
    import sle_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  wire             clk,
    input  wire             rst_n,
    input  wire             s_tvalid,
    input  wire             s_tready,
    input  wire [IN_W-1:0]  s_tdata,
    input  wire             m_tvalid,
    input  wire             m_tready,
    input  wire [OUT_W-1:0] m_tdata,
    output int              mismatches,
    output int              outstanding,
    output int              checked,
    output int              full_seen,
    output int              empty_seen,
    output int              miss_seen
);

    typedef struct packed {
        status_t            status;
        logic [POS_W-1:0]   position;
        logic [CNT_W-1:0]   entry_count;
    } outcome_t;

    value_t   held_values [DEPTH];
    int       held;
    outcome_t awaited [$];
    outcome_t want;
    outcome_t got;
    int       bad;

    function automatic outcome_t apply_word(input logic [OP_W-1:0] op, input value_t v);
        outcome_t r;
        int       slot;
        int       i;
        r.status   = STATUS_OK;
        r.position = '0;
        case (op)
            OP_INSERT, OP_PUSH_FRONT, OP_PUSH_BACK:
            begin
                if (held >= DEPTH)
                begin
                    r.status = STATUS_FULL;
                end
                else
                begin
                    if (op == OP_INSERT)
                    begin
                        slot = held;
                        for (i = 0; i < held; i++)
                        begin
                            if (held_values[i] > v)
                            begin
                                slot = i;
                                break;
                            end
                        end
                    end
                    else if (op == OP_PUSH_FRONT)
                    begin
                        slot = 0;
                    end
                    else
                    begin
                        slot = held;
                    end
                    for (i = held; i > slot; i--)
                    begin
                        held_values[i] = held_values[i-1];
                    end
                    held_values[slot] = v;
                    held++;
                    r.position = POS_W'(slot);
                end
            end
            OP_POP_FRONT:
            begin
                if (held == 0)
                begin
                    r.status = STATUS_EMPTY;
                end
                else
                begin
                    for (i = 1; i < held; i++)
                    begin
                        held_values[i-1] = held_values[i];
                    end
                    held--;
                end
            end
            OP_POP_BACK:
            begin
                if (held == 0)
                begin
                    r.status = STATUS_EMPTY;
                end
                else
                begin
                    held--;
                end
            end
            OP_FIND:
            begin
                r.status = STATUS_NOT_FOUND;
                for (i = 0; i < held; i++)
                begin
                    if (held_values[i] == v)
                    begin
                        r.status   = STATUS_OK;
                        r.position = POS_W'(i);
                        break;
                    end
                end
            end
            default:
            begin
                // spare codes leave the list alone
            end
        endcase
        r.entry_count = CNT_W'(held);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held = 0;
            awaited.delete();
            mismatches  <= 0;
            outstanding <= 0;
            checked     <= 0;
            full_seen   <= 0;
            empty_seen  <= 0;
            miss_seen   <= 0;
        end
        else
        begin
            bad = 0;
            // results first: a word accepted at this edge cannot answer yet
            if (m_tvalid && m_tready)
            begin
                got.status      = status_t'(m_tdata[1:0]);
                got.position    = m_tdata[5:2];
                got.entry_count = m_tdata[10:6];
                if (awaited.size() == 0)
                begin
                    $display("%0t: unexpected result word, expected none, got status %0d position %0d count %0d",
                             $time, got.status, got.position, got.entry_count);
                    bad++;
                end
                else
                begin
                    want = awaited.pop_front();
                    if (got.status !== want.status)
                    begin
                        $display("%0t: status mismatch, expected %0d, got %0d",
                                 $time, want.status, got.status);
                        bad++;
                    end
                    if (got.position !== want.position)
                    begin
                        $display("%0t: position mismatch, expected %0d, got %0d",
                                 $time, want.position, got.position);
                        bad++;
                    end
                    if (got.entry_count !== want.entry_count)
                    begin
                        $display("%0t: entry count mismatch, expected %0d, got %0d",
                                 $time, want.entry_count, got.entry_count);
                        bad++;
                    end
                end
                checked <= checked + 1;
            end
            if (s_tvalid && s_tready)
            begin
                want = apply_word(s_tdata[OP_W-1:0], value_t'(s_tdata[OP_W+VALUE_W-1:OP_W]));
                awaited.push_back(want);
                if (want.status == STATUS_FULL)
                begin
                    full_seen <= full_seen + 1;
                end
                if (want.status == STATUS_EMPTY)
                begin
                    empty_seen <= empty_seen + 1;
                end
                if (want.status == STATUS_NOT_FOUND)
                begin
                    miss_seen <= miss_seen + 1;
                end
            end
            mismatches  <= mismatches + bad;
            outstanding <= awaited.size();
        end
    end

endmodule

`default_nettype wire

### tb/tb.sv
`default_nettype none

module tb;
    import sle_pkg::*;

    localparam int DEPTH = 16;
    localparam logic [OP_W-1:0] OP_SPARE_A = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_B = 3'd7;
    localparam value_t VALUE_MIN = value_t'(32'h8000_0000);
    localparam value_t VALUE_MAX = value_t'(32'h7fff_ffff);

    typedef enum int {
        MODE_FILL,
        MODE_DRAIN,
        MODE_MIXED
    } phase_mode_t;

    logic             clk;
    logic             rst_n;
    logic             s_tvalid;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata;
    logic             m_tvalid;
    logic             m_tready;
    logic [OUT_W-1:0] m_tdata;

    int mismatches;
    int outstanding;
    int checked;
    int full_seen;
    int empty_seen;
    int miss_seen;

    bit          src_busy  = 1'b1;
    bit          sink_busy = 1'b1;
    value_t      recent [8];
    int          recent_wr = 0;
    int          words_sent = 0;
    int          phase;
    phase_mode_t mode;

    sorted_list_engine #(
        .DEPTH (DEPTH)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    list_result_checker #(
        .DEPTH (DEPTH)
    ) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .mismatches  (mismatches),
        .outstanding (outstanding),
        .checked     (checked),
        .full_seen   (full_seen),
        .empty_seen  (empty_seen),
        .miss_seen   (miss_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #3000000;
        $display("FAILURE");
        $finish;
    end

    // result side: random stall before each word while the sink is busy
    initial
    begin
        int stall;
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            stall = sink_busy ? $urandom_range(0, 19) : 0;
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!(m_tvalid && m_tready));
            @(negedge clk);
        end
    end

    function automatic logic [OP_W-1:0] pick_op(input phase_mode_t m);
        int cut [6];
        int roll;
        case (m)
            MODE_FILL:  cut = '{45, 55, 65, 72, 78, 96};
            MODE_DRAIN: cut = '{10, 15, 20, 50, 80, 96};
            default:    cut = '{25, 35, 45, 60, 75, 96};
        endcase
        roll = $urandom_range(0, 99);
        if (roll < cut[0]) return OP_INSERT;
        if (roll < cut[1]) return OP_PUSH_FRONT;
        if (roll < cut[2]) return OP_PUSH_BACK;
        if (roll < cut[3]) return OP_POP_FRONT;
        if (roll < cut[4]) return OP_POP_BACK;
        if (roll < cut[5]) return OP_FIND;
        return $urandom_range(0, 1) ? OP_SPARE_B : OP_SPARE_A;
    endfunction

    // small values give duplicates and find hits, recent ones give more hits
    function automatic value_t pick_value();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 4) return value_t'($urandom_range(0, 8)) - value_t'(4);
        if (roll == 4)
        begin
            case ($urandom_range(0, 3))
                0:       return VALUE_MIN;
                1:       return VALUE_MAX;
                2:       return VALUE_MIN + value_t'(1);
                default: return VALUE_MAX - value_t'(1);
            endcase
        end
        if (roll < 7) return recent[$urandom_range(0, 7)];
        return value_t'($urandom);
    endfunction

    task automatic send_word(input logic [OP_W-1:0] op, input value_t v);
        int gap;
        gap = src_busy ? $urandom_range(0, 19) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_W-OP_W-VALUE_W){1'b0}}, v, op};
        do @(posedge clk); while (!s_tready);
        @(negedge clk);
        words_sent++;
        if (op == OP_INSERT || op == OP_PUSH_FRONT || op == OP_PUSH_BACK)
        begin
            recent[recent_wr] = v;
            recent_wr = (recent_wr + 1) % 8;
        end
    endtask

    initial
    begin
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        foreach (recent[i])
        begin
            recent[i] = value_t'(i);
        end
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // empty list, spare codes
        send_word(OP_POP_FRONT, value_t'(0));
        send_word(OP_POP_BACK, value_t'(0));
        send_word(OP_FIND, value_t'(0));
        send_word(OP_SPARE_A, VALUE_MAX);
        send_word(OP_SPARE_B, VALUE_MIN);
        // extremes, equal values, pushes
        send_word(OP_INSERT, value_t'(0));
        send_word(OP_INSERT, VALUE_MAX);
        send_word(OP_INSERT, VALUE_MIN);
        send_word(OP_INSERT, value_t'(-1));
        send_word(OP_INSERT, value_t'(0));
        send_word(OP_PUSH_FRONT, value_t'(5));
        send_word(OP_PUSH_BACK, value_t'(-5));
        send_word(OP_INSERT, value_t'(1));
        send_word(OP_FIND, value_t'(0));
        send_word(OP_FIND, VALUE_MIN);
        send_word(OP_FIND, value_t'(-5));
        send_word(OP_FIND, value_t'(77));
        send_word(OP_POP_FRONT, value_t'(0));
        send_word(OP_POP_BACK, value_t'(0));
        send_word(OP_FIND, value_t'(5));

        for (phase = 0; phase < 15; phase++)
        begin
            mode      = (phase == 0) ? MODE_FILL : phase_mode_t'($urandom_range(0, 2));
            src_busy  = ($urandom_range(0, 3) != 0);
            sink_busy = ($urandom_range(0, 3) != 0);
            repeat (60)
            begin
                send_word(pick_op(mode), pick_value());
            end
        end
        s_tvalid <= 1'b0;

        while (outstanding != 0) @(posedge clk);
        repeat (20) @(posedge clk);

        $display("%0d words sent through fill, drain and mixed phases, %0d results checked",
                 words_sent, checked);
        $display("full list hits %0d, empty list hits %0d, not found %0d",
                 full_seen, empty_seen, miss_seen);
        if (mismatches == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

`default_nettype wire
